@@ sv/drop_oldest_byte_ring_buffer_macros.svh @@
// Assertion macros shared by the checker of the drop-oldest byte ring buffer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DROP_OLDEST_BYTE_RING_BUFFER_MACROS_SVH
`define DROP_OLDEST_BYTE_RING_BUFFER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DOBRB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DOBRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dobrb_pkg.sv @@
// Package for the drop-oldest byte ring buffer: payload structs, command codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package dobrb_pkg;

  localparam int CfgW  = 17;
  localparam int LenW  = 20;
  localparam int AddrW = 3;
  localparam int DataW = 32;

  // Command codes of an input item.
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_TARGET   = 1'b1;

  localparam logic [CfgW-1:0] CAPACITY_RESET = 17'd65536;
  localparam logic [CfgW-1:0] TARGET_RESET   = 17'd0;
  localparam logic [LenW-1:0] DROP_MAX       = 20'hFFFFF;

  typedef struct packed {
    logic [1:0]      command;
    logic [7:0]      data_byte;
    logic            first_in_chunk;
    logic [LenW-1:0] chunk_length;
  } req_t;

  typedef struct packed {
    logic [7:0]      read_byte;
    logic            read_valid;
    logic            byte_accepted;
    logic [LenW-1:0] dropped_bytes;
    logic            resynced;
    logic [CfgW-1:0] fill_level;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SIZE,
    ST_TRIM,
    ST_ADVANCE,
    ST_PUSH,
    ST_POP,
    ST_DONE
  } state_t;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic size;
    logic trim;
    logic advance;
    logic push;
    logic pop;
    logic clear;
  } dp_cmd_t;

  // Status of the latched item for the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       first;
    logic       eff_zero;
  } dp_stat_t;

endpackage

@@ sv/dobrb_cfg.sv @@
// APB-style register file for capacity_bytes and target_bytes.
// Uses dobrb_pkg; a write also pulses clear_buf to empty the ring.
`timescale 1ns / 1ps

module dobrb_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dobrb_pkg::AddrW-1:0] paddr,
  input  logic [dobrb_pkg::DataW-1:0] pwdata,
  output logic [dobrb_pkg::DataW-1:0] prdata,
  output logic                        pready,
  output logic [dobrb_pkg::CfgW-1:0]  capacity,
  output logic [dobrb_pkg::CfgW-1:0]  target,
  output logic                        clear_buf
);

  logic wr_en;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign clear_buf = wr_en;

  // The byte offset in paddr[1:0] is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= dobrb_pkg::CAPACITY_RESET;
      target   <= dobrb_pkg::TARGET_RESET;
    end else if (wr_en) begin
      if (paddr[2] == dobrb_pkg::REG_TARGET) begin
        target <= pwdata[dobrb_pkg::CfgW-1:0];
      end else begin
        capacity <= pwdata[dobrb_pkg::CfgW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == dobrb_pkg::REG_TARGET) begin
      prdata = dobrb_pkg::DataW'(target);
    end else begin
      prdata = dobrb_pkg::DataW'(capacity);
    end
  end

endmodule

@@ sv/dobrb_ctrl.sv @@
// Controller of the drop-oldest byte ring buffer: sequences the datapath steps.
// Uses dobrb_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps

module dobrb_ctrl (
  input  logic                rst,
  input  logic                clk,
  input  logic                start,
  input  dobrb_pkg::dp_stat_t stat,
  output dobrb_pkg::dp_cmd_t  cmd,
  output logic                busy,
  output logic                done
);

  dobrb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dobrb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != dobrb_pkg::ST_IDLE);
  assign done = (state == dobrb_pkg::ST_DONE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      dobrb_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = dobrb_pkg::ST_DECODE;
        end
      end
      dobrb_pkg::ST_DECODE: begin
        // A push with no usable capacity changes nothing at all.
        if (stat.command == dobrb_pkg::CMD_PUSH && !stat.eff_zero) begin
          state_next = stat.first ? dobrb_pkg::ST_SIZE : dobrb_pkg::ST_PUSH;
        end else if (stat.command == dobrb_pkg::CMD_POP) begin
          state_next = dobrb_pkg::ST_POP;
        end else if (stat.command == dobrb_pkg::CMD_CLEAR) begin
          cmd.clear  = 1'b1;
          state_next = dobrb_pkg::ST_DONE;
        end else begin
          state_next = dobrb_pkg::ST_DONE;
        end
      end
      dobrb_pkg::ST_SIZE: begin
        cmd.size   = 1'b1;
        state_next = dobrb_pkg::ST_TRIM;
      end
      dobrb_pkg::ST_TRIM: begin
        cmd.trim   = 1'b1;
        state_next = dobrb_pkg::ST_ADVANCE;
      end
      dobrb_pkg::ST_ADVANCE: begin
        cmd.advance = 1'b1;
        state_next  = dobrb_pkg::ST_PUSH;
      end
      dobrb_pkg::ST_PUSH: begin
        cmd.push   = 1'b1;
        state_next = dobrb_pkg::ST_DONE;
      end
      dobrb_pkg::ST_POP: begin
        cmd.pop    = 1'b1;
        state_next = dobrb_pkg::ST_DONE;
      end
      dobrb_pkg::ST_DONE: begin
        state_next = dobrb_pkg::ST_IDLE;
      end
      default: begin
        state_next = dobrb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/dobrb_dp.sv @@
// Datapath of the drop-oldest byte ring buffer: byte store, pointers, fill count,
// skip counter and result registers. Uses dobrb_pkg; steered by dobrb_ctrl.
`timescale 1ns / 1ps

module dobrb_dp #(
  parameter int DEPTH = 65536
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dobrb_pkg::dp_cmd_t         cmd,
  input  dobrb_pkg::req_t            request,
  input  logic [dobrb_pkg::CfgW-1:0] capacity,
  input  logic [dobrb_pkg::CfgW-1:0] target,
  input  logic                       clear_buf,
  output dobrb_pkg::dp_stat_t        stat,
  output dobrb_pkg::rsp_t            result
);

  localparam int          AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [20:0] DepthW = 21'(DEPTH);
  localparam int          CW     = dobrb_pkg::CfgW;
  localparam int          LW     = dobrb_pkg::LenW;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;

  logic [CW-1:0] eff;
  logic [CW-1:0] eff_next;
  logic [CW-1:0] cfg_max;

  // Latched item.
  logic [1:0]    cmd_code;
  logic [7:0]    byte_q;
  logic          first_q;
  logic [LW-1:0] len_q;

  // Buffer state.
  logic [CW-1:0] rp;
  logic [CW-1:0] fill;
  logic [LW-1:0] skip;

  // Chunk-start working registers.
  logic [20:0]   sum;
  logic [CW-1:0] live;
  logic          big;
  logic [CW-1:0] disc;

  // Result registers.
  logic          res_rvalid;
  logic          res_acc;
  logic [LW-1:0] res_drop;
  logic          res_resync;

  logic [LW-1:0] len_max;
  logic [CW-1:0] live_next;
  logic [20:0]   over_big;
  logic [20:0]   over_live;
  logic [CW-1:0] disc_next;
  logic [17:0]   rp_adv;
  logic [17:0]   rp_adv_wrap;
  logic [17:0]   wsum;
  logic [17:0]   wptr;
  logic [17:0]   rp_inc;
  logic          mem_we;
  logic          mem_re;

  // Effective capacity, saturated to the store depth; registered off the config.
  assign cfg_max  = (capacity > target) ? capacity : target;
  assign eff_next = (21'(cfg_max) > DepthW) ? DepthW[CW-1:0] : cfg_max;

  always_ff @(posedge clk) begin
    eff <= eff_next;
  end

  assign len_max   = (LW'(target) > len_q) ? LW'(target) : len_q;
  assign live_next = (len_max > LW'(eff)) ? eff : len_max[CW-1:0];
  assign over_big  = sum - 21'(eff);
  assign over_live = sum - 21'(live);
  assign disc_next = (over_live > 21'(fill)) ? fill : over_live[CW-1:0];

  assign rp_adv      = 18'(rp) + 18'(disc);
  assign rp_adv_wrap = (rp_adv >= 18'(eff)) ? rp_adv - 18'(eff) : rp_adv;
  assign wsum        = 18'(rp) + 18'(fill);
  assign wptr        = (wsum >= 18'(eff)) ? wsum - 18'(eff) : wsum;
  assign rp_inc      = 18'(rp) + 18'd1;

  assign mem_we = cmd.push && (skip == '0) && (fill < eff);
  assign mem_re = cmd.pop && (fill != '0) && (eff != '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(wptr)] <= byte_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[AW'(rp)];
    end
  end

  // Latched item and chunk-start working values.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_code <= request.command;
      byte_q   <= request.data_byte;
      first_q  <= request.first_in_chunk;
      // A zero chunk length counts as one.
      len_q    <= (request.chunk_length == '0) ? LW'(1) : request.chunk_length;
    end
    if (cmd.size) begin
      sum  <= 21'(fill) + 21'(len_q);
      live <= live_next;
      big  <= (len_q >= LW'(eff));
    end
  end

  // Result flags; cleared on capture so that items without an effect report zero.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_rvalid <= 1'b0;
      res_acc    <= 1'b0;
      res_drop   <= '0;
      res_resync <= 1'b0;
    end else begin
      if (cmd.trim) begin
        if (big) begin
          res_drop   <= (over_big > 21'(dobrb_pkg::DROP_MAX)) ? dobrb_pkg::DROP_MAX
                                                              : over_big[LW-1:0];
          res_resync <= (over_big != '0);
        end else if (sum > 21'(eff)) begin
          res_drop   <= LW'(disc_next);
          res_resync <= 1'b1;
        end
      end
      if (mem_we) begin
        res_acc <= 1'b1;
      end
      if (mem_re) begin
        res_rvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      disc <= (!big && sum > 21'(eff)) ? disc_next : '0;
    end
  end

  // Ring pointers, fill count and skip counter.
  always_ff @(posedge clk) begin
    if (rst || clear_buf || cmd.clear) begin
      rp   <= '0;
      fill <= '0;
      skip <= '0;
    end else if (cmd.trim) begin
      if (big) begin
        // The chunk alone fills the ring: empty it and skip the chunk's leading excess.
        rp   <= '0;
        fill <= '0;
        skip <= len_q - LW'(eff);
      end else begin
        skip <= '0;
      end
    end else if (cmd.advance) begin
      rp   <= rp_adv_wrap[CW-1:0];
      fill <= fill - disc;
    end else if (cmd.push) begin
      if (skip != '0) begin
        skip <= skip - LW'(1);
      end else if (fill < eff) begin
        fill <= fill + CW'(1);
      end
    end else if (mem_re) begin
      rp   <= (rp_inc >= 18'(eff)) ? '0 : rp_inc[CW-1:0];
      fill <= fill - CW'(1);
    end
  end

  assign stat.command  = cmd_code;
  assign stat.first    = first_q;
  assign stat.eff_zero = (eff == '0);

  assign result.read_byte     = res_rvalid ? rdata : 8'd0;
  assign result.read_valid    = res_rvalid;
  assign result.byte_accepted = res_acc;
  assign result.dropped_bytes = res_drop;
  assign result.resynced      = res_resync;
  assign result.fill_level    = fill;

endmodule

@@ sv/drop_oldest_byte_ring_buffer.sv @@
// Drop-oldest byte ring buffer for a live audio stream.
// Command channel: an item (request) is taken at a rising edge with start high and
// busy low. Its command pushes a byte, pops the oldest byte or clears the ring. The
// first pushed byte of a chunk carries the chunk length; an overflowing chunk discards
// the oldest bytes so that it and the kept bytes fill max(target, chunk length), and a
// chunk of at least the capacity empties the ring and skips its own leading excess bytes.
// Result channel: every item gives one result, shown on result for the single cycle in
// which done is high; the receiver cannot hold it off.
// Sequence from the accepting edge: the item is decoded; a clear or no-op then goes to done,
// a pop or an ordinary push first runs its pop or push step, and the first byte of a chunk
// first runs the three chunk-start steps (size, trim, advance) and then its push step. busy
// falls in the cycle after done. A pop waits for the registered store read.
// Configuration: capacity_bytes at byte address 0, target_bytes at 4; a write also empties
// the ring. Reset returns the registers to 65536 and 0 and empties the ring; the byte
// store itself is not cleared.
// Uses dobrb_pkg, dobrb_cfg, dobrb_ctrl and dobrb_dp.
`timescale 1ns / 1ps

module drop_oldest_byte_ring_buffer #(
  parameter int DEPTH = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  dobrb_pkg::req_t             request,
  output logic                        busy,
  output logic                        done,
  output dobrb_pkg::rsp_t             result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dobrb_pkg::AddrW-1:0] paddr,
  input  logic [dobrb_pkg::DataW-1:0] pwdata,
  output logic [dobrb_pkg::DataW-1:0] prdata,
  output logic                        pready
);

  logic [dobrb_pkg::CfgW-1:0] capacity;
  logic [dobrb_pkg::CfgW-1:0] target;
  logic                       clear_buf;
  dobrb_pkg::dp_cmd_t         dp_cmd;
  dobrb_pkg::dp_stat_t        dp_stat;

  dobrb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .capacity  (capacity),
    .target    (target),
    .clear_buf (clear_buf)
  );

  dobrb_ctrl u_ctrl (
    .rst   (rst),
    .clk   (clk),
    .start (start),
    .stat  (dp_stat),
    .cmd   (dp_cmd),
    .busy  (busy),
    .done  (done)
  );

  dobrb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .request   (request),
    .capacity  (capacity),
    .target    (target),
    .clear_buf (clear_buf),
    .stat      (dp_stat),
    .result    (result)
  );

endmodule

@@ sv/dobrb_checker.sv @@
// Port-level checker for the drop-oldest byte ring buffer, bound to the top level.
// Uses dobrb_pkg and the macros in drop_oldest_byte_ring_buffer_macros.svh.
`timescale 1ns / 1ps
`include "drop_oldest_byte_ring_buffer_macros.svh"

module dobrb_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input dobrb_pkg::rsp_t result
);

  // An accepted item keeps the block busy until its result has gone out.
  `DOBRB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

  // Each item gives a single one-cycle result.
  `DOBRB_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held for two cycles")

  // Every result, not only a chunk start's, reports a resync exactly when bytes were discarded.
  `DOBRB_ASSERT_SAME(a_resync_drop, done, result.resynced == (result.dropped_bytes != '0), "resynced disagrees with dropped_bytes")

  // A result that carries no popped byte shows zero on read_byte.
  `DOBRB_ASSERT_SAME(a_idle_byte, done && !result.read_valid, result.read_byte == 8'd0, "read_byte not zero without a popped byte")

endmodule

bind drop_oldest_byte_ring_buffer dobrb_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

@@ dv/testbench.sv @@
// Self-checking testbench for the drop-oldest byte ring buffer.
// Drives push, pop and clear items plus APB register writes, predicts every result
// in a scoreboard class and compares it field by field. Depends on dobrb_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int RING_DEPTH = 65536;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int PHASE_COUNT = 14;
  localparam int PHASE_ITEMS = 138;

  // Scoreboard: keeps its own copy of the ring and the registers.
  class byte_ring_tracker;
    logic [7:0]        ring_mem [RING_DEPTH];
    int unsigned       capacity;
    int unsigned       target;
    int unsigned       rd_ptr;
    int unsigned       fill;
    int unsigned       skip;
    dobrb_pkg::rsp_t   pending_results[$];
    int unsigned       error_count;

    function new();
      capacity = 32'(dobrb_pkg::CAPACITY_RESET);
      target = 32'(dobrb_pkg::TARGET_RESET);
      error_count = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      rd_ptr = 0;
      fill = 0;
      skip = 0;
    endfunction

    function int unsigned live_capacity();
      int unsigned e;
      e = (capacity > target) ? capacity : target;
      return (e > RING_DEPTH) ? RING_DEPTH : e;
    endfunction

    function void write_register(logic reg_idx, logic [dobrb_pkg::DataW-1:0] value);
      if (reg_idx == dobrb_pkg::REG_CAPACITY) capacity = 32'(value[dobrb_pkg::CfgW-1:0]);
      else target = 32'(value[dobrb_pkg::CfgW-1:0]);
      clear_ring();
    endfunction

    function void apply_request(dobrb_pkg::req_t r);
      dobrb_pkg::rsp_t x;
      int unsigned     e;
      int unsigned     len;
      int unsigned     keep;
      int unsigned     disc;
      int unsigned     slot;
      longint unsigned drop;
      x = '0;
      drop = 0;
      e = live_capacity();
      if (r.command == dobrb_pkg::CMD_PUSH && e != 0) begin
        if (r.first_in_chunk) begin
          len = (r.chunk_length == 0) ? 1 : 32'(r.chunk_length);
          if (len >= e) begin
            // The chunk alone fills the ring: empty it and skip the leading excess.
            drop = longint'(fill) + len - e;
            x.resynced = (drop != 0);
            rd_ptr = 0;
            fill = 0;
            skip = len - e;
          end else begin
            skip = 0;
            if (fill + len > e) begin
              keep = (target > len) ? target : len;
              if (keep > e) keep = e;
              disc = fill + len - keep;
              if (disc > fill) disc = fill;
              rd_ptr += disc;
              if (rd_ptr >= e) rd_ptr -= e;
              fill -= disc;
              drop = 64'(disc);
              x.resynced = 1'b1;
            end
          end
        end
        if (skip != 0) begin
          skip--;
        end else if (fill < e) begin
          slot = rd_ptr + fill;
          if (slot >= e) slot -= e;
          ring_mem[slot % RING_DEPTH] = r.data_byte;
          fill++;
          x.byte_accepted = 1'b1;
        end
      end else if (r.command == dobrb_pkg::CMD_POP) begin
        if (fill != 0 && e != 0) begin
          x.read_byte = ring_mem[rd_ptr % RING_DEPTH];
          x.read_valid = 1'b1;
          rd_ptr++;
          if (rd_ptr >= e) rd_ptr = 0;
          fill--;
        end
      end else if (r.command == dobrb_pkg::CMD_CLEAR) begin
        clear_ring();
      end
      x.dropped_bytes = (drop > dobrb_pkg::DROP_MAX) ? dobrb_pkg::DROP_MAX
                                                     : dobrb_pkg::LenW'(drop);
      x.fill_level = dobrb_pkg::CfgW'(fill);
      pending_results.push_back(x);
    endfunction

    function void check_result(dobrb_pkg::rsp_t got);
      dobrb_pkg::rsp_t want;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result with nothing pending: %p", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_byte !== want.read_byte || got.read_valid !== want.read_valid ||
          got.byte_accepted !== want.byte_accepted ||
          got.dropped_bytes !== want.dropped_bytes || got.resynced !== want.resynced ||
          got.fill_level !== want.fill_level) begin
        error_count++;
        if (error_count <= 10) begin
          $display("expected byte=%02h valid=%0b acc=%0b drop=%0d resync=%0b fill=%0d",
                   want.read_byte, want.read_valid, want.byte_accepted,
                   want.dropped_bytes, want.resynced, want.fill_level);
          $display("     got byte=%02h valid=%0b acc=%0b drop=%0d resync=%0b fill=%0d",
                   got.read_byte, got.read_valid, got.byte_accepted,
                   got.dropped_bytes, got.resynced, got.fill_level);
        end
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        start;
  dobrb_pkg::req_t             request;
  logic                        busy;
  logic                        done;
  dobrb_pkg::rsp_t             result;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [dobrb_pkg::AddrW-1:0] paddr;
  logic [dobrb_pkg::DataW-1:0] pwdata;
  logic [dobrb_pkg::DataW-1:0] prdata;
  logic                        pready;

  byte_ring_tracker tracker;
  int               idle_max;

  drop_oldest_byte_ring_buffer u_dut (
    .clk(clk), .rst(rst), .start(start), .request(request), .busy(busy), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.apply_request(request);
      if (done) tracker.check_result(result);
    end
  end

  // Holds start high across back-to-back items; for a gap, the idle cycles are
  // counted from the cycle in which the block is ready again.
  task automatic send_item(input dobrb_pkg::req_t r);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      while (busy) @(negedge clk);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic issue(input logic [1:0] cmd, input logic [7:0] data, input logic first,
                       input logic [dobrb_pkg::LenW-1:0] len);
    dobrb_pkg::req_t r;
    r.command = cmd;
    r.data_byte = data;
    r.first_in_chunk = first;
    r.chunk_length = len;
    send_item(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_register(input logic reg_idx, input int unsigned value);
    logic [dobrb_pkg::DataW-1:0] data;
    data = value;
    // Bits above the register width must be ignored by the block.
    if ($urandom_range(0, 1)) begin
      data[dobrb_pkg::DataW-1:dobrb_pkg::CfgW] = (dobrb_pkg::DataW - dobrb_pkg::CfgW)'($urandom);
    end
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_register(reg_idx, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic directed_items();
    idle_max = 4;
    issue(dobrb_pkg::CMD_POP, 8'h00, 1'b0, '0);
    issue(dobrb_pkg::CMD_PUSH, 8'h00, 1'b1, 20'd0);
    issue(dobrb_pkg::CMD_PUSH, 8'hFF, 1'b1, 20'd1);
    issue(dobrb_pkg::CMD_PUSH, 8'hA5, 1'b0, 20'hFFFFF);
    repeat (4) issue(dobrb_pkg::CMD_POP, 8'hFF, 1'b1, 20'hFFFFF);
    issue(CMD_NONE, 8'hFF, 1'b1, 20'hFFFFF);
    issue(dobrb_pkg::CMD_PUSH, 8'h11, 1'b1, 20'd2);
    issue(dobrb_pkg::CMD_PUSH, 8'h22, 1'b0, 20'd0);
    issue(dobrb_pkg::CMD_CLEAR, 8'hFF, 1'b1, 20'hFFFFF);
    issue(dobrb_pkg::CMD_POP, 8'h00, 1'b0, '0);
    // A chunk far longer than the ring: its leading bytes are skipped.
    issue(dobrb_pkg::CMD_PUSH, 8'h5A, 1'b1, 20'hFFFFF);
    repeat (2) issue(dobrb_pkg::CMD_PUSH, 8'h5B, 1'b0, 20'd0);
    issue(dobrb_pkg::CMD_PUSH, 8'h3C, 1'b1, 20'd65536);
    issue(dobrb_pkg::CMD_PUSH, 8'h3D, 1'b1, 20'd65535);
    repeat (3) issue(dobrb_pkg::CMD_POP, 8'h00, 1'b0, '0);
  endtask

  // Mostly well-formed chunks and pop bursts, with broken chunks and noise mixed in.
  task automatic random_items(input int count);
    int                          sent;
    int                          pick;
    int                          len;
    int                          n;
    int unsigned                 e;
    int                          chunk_cap;
    logic [dobrb_pkg::LenW-1:0]  len_field;
    sent = 0;
    e = tracker.live_capacity();
    chunk_cap = (e == 0) ? 8 : int'((e + e / 2 + 2 < 48) ? e + e / 2 + 2 : 48);
    while (sent < count) begin
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = $urandom_range(1, chunk_cap);
        n = len;
        len_field = dobrb_pkg::LenW'(len);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, len + 3);
        if ($urandom_range(0, 19) == 0) begin
          len_field = ($urandom_range(0, 1)) ? dobrb_pkg::LenW'(e + $urandom_range(0, 3))
                                             : dobrb_pkg::LenW'($urandom);
          n = $urandom_range(1, 6);
        end
        for (int k = 0; k < n; k++) begin
          issue(dobrb_pkg::CMD_PUSH, 8'($urandom), k == 0,
                (k == 0) ? len_field : dobrb_pkg::LenW'($urandom));
          sent++;
        end
      end else if (pick < 87) begin
        n = $urandom_range(1, chunk_cap);
        for (int k = 0; k < n; k++) begin
          issue(dobrb_pkg::CMD_POP, 8'($urandom), 1'($urandom), dobrb_pkg::LenW'($urandom));
          sent++;
        end
      end else if (pick < 90) begin
        issue(dobrb_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom), dobrb_pkg::LenW'($urandom));
        sent++;
      end else begin
        issue(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
              dobrb_pkg::LenW'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned cap_list [PHASE_COUNT];
    int unsigned tgt_list [PHASE_COUNT];
    cap_list = '{8, 16, 1, 0, 0, 65536, 131071, 100000, 3, 200, 0, 0, 0, 0};
    tgt_list = '{0, 12, 0, 0, 5, 0, 131071, 3, 65536, 150, 0, 0, 0, 0};
    tracker = new();
    idle_max = 4;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_items();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p >= 10) begin
        cap_list[p] = $urandom_range(1, 40);
        tgt_list[p] = $urandom_range(0, 48);
      end
      wait_idle();
      write_register(dobrb_pkg::REG_CAPACITY, cap_list[p]);
      write_register(dobrb_pkg::REG_TARGET, tgt_list[p]);
      random_items((cap_list[p] == 0 && tgt_list[p] == 0) ? 60 : PHASE_ITEMS);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (tracker.error_count == 0 && tracker.pending_results.size() == 0) begin
      $display("drop_oldest_byte_ring_buffer: match");
    end else begin
      $display("drop_oldest_byte_ring_buffer: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("drop_oldest_byte_ring_buffer: mismatch");
    $finish;
  end

endmodule
